// ----- sv/rrts_pkg.sv -----
// Shared types and constants for the round-robin task switcher.
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int DEF_TASK_SLOTS = 8;

    localparam logic [1:0] REQ_SWITCH = 2'd0;
    localparam logic [1:0] REQ_CREATE = 2'd1;
    localparam logic [1:0] REQ_EXIT   = 2'd2;

    localparam logic [1:0]  FLAG_IN_USE = 2'h1;
    localparam logic [1:0]  FLAG_EXEC   = 2'h2;
    localparam logic [31:0] FRAME_BYTES = 32'd64;

    // sequencer -> scan unit
    typedef struct packed {
        logic start;        // load counter with start index
        logic step;         // advance counter by one slot
        logic create_mode;  // hit on free slot instead of executable slot
        logic set_en;       // mark slot under counter in use + executable
        logic clr_en;       // clear flags of slot at clear index
    } t_scan_ctl;

    // scan unit -> sequencer
    typedef struct packed {
        logic at_end;       // counter ran past the last slot
        logic hit;          // slot under counter matches the scan mode
    } t_scan_sts;

endpackage

// ----- sv/round_robin_task_switcher.sv -----
// Round-robin task switcher top level: request sequencer and result register.
`timescale 1ns / 1ps
// Sequence: a switch scans the flags from the slot after the running task, reads the saved
//   stack pointer (S_READ) and loads the result (S_OUT); a create scans from slot 1, then
//   loads; exit and unused codes load directly. One request at a time; ready returns when
//   the result is loaded, which waits while the output stalls; the slot scan sets the rate.
// Reset (i_rst_n low, synchronous): running task 0, all task flags cleared, no result
//   pending. Saved stack pointers are not cleared; no clearing pass.
module round_robin_task_switcher #(
    parameter int TASK_SLOTS = rrts_pkg::DEF_TASK_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] stack_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [2:0] task_slot, [34:3] stack_out, [39:35] zero
    output logic [0:0]  o_m_axis_tuser    // [0] status
);
    import rrts_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_OUT
    } t_state;

    t_state            r_state;
    logic              r_is_create;
    logic [SLOT_W-1:0] r_running;
    logic [31:0]       r_new_sp;
    logic [SLOT_W-1:0] r_res_slot;
    logic [31:0]       r_res_sp;
    logic              r_res_status;
    logic              r_out_valid;
    logic [2:0]        r_out_slot;
    logic [31:0]       r_out_sp;
    logic              r_out_status;

    t_scan_ctl         scan_ctl;
    t_scan_sts         scan_sts;
    logic [CNT_W-1:0]  scan_idx;
    logic [CNT_W-1:0]  start_idx;
    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              scan_done;
    logic [SLOT_W-1:0] found_slot;
    logic [SLOT_W+2:0] res_slot_ext;

    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic [31:0]       mem_wr_data;
    logic              mem_rd_en;
    logic [31:0]       mem_rd_data;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign out_load        = (r_state == S_OUT) && out_free;
    assign scan_done       = scan_sts.at_end || scan_sts.hit;
    assign found_slot      = scan_sts.at_end ? '0 : scan_idx[SLOT_W-1:0];
    // low 3 bits of the slot index, zero-filled for small tables
    assign res_slot_ext    = {3'b000, r_res_slot};

    always_comb begin
        scan_ctl             = '0;
        scan_ctl.create_mode = r_is_create;
        start_idx            = CNT_W'(r_running) + CNT_W'(1);
        mem_wr_en            = 1'b0;
        mem_wr_addr          = r_running;
        mem_wr_data          = i_s_axis_tdata;
        mem_rd_en            = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_s_axis_tuser)
                        REQ_SWITCH: begin
                            scan_ctl.start = 1'b1;
                            mem_wr_en      = 1'b1;
                        end
                        REQ_CREATE: begin
                            scan_ctl.start = 1'b1;
                            start_idx      = CNT_W'(1);
                        end
                        REQ_EXIT: begin
                            scan_ctl.clr_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!scan_done) begin
                    scan_ctl.step = 1'b1;
                end else if (r_is_create) begin
                    if (!scan_sts.at_end) begin
                        scan_ctl.set_en = 1'b1;
                        mem_wr_en       = 1'b1;
                        mem_wr_addr     = scan_idx[SLOT_W-1:0];
                        mem_wr_data     = r_new_sp;
                    end
                end else begin
                    mem_rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    rrts_scan_unit #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_start_idx (start_idx),
        .i_clr_idx   (r_running),
        .o_sts       (scan_sts),
        .o_idx       (scan_idx)
    );

    rrts_stack_mem #(
        .DEPTH  (TASK_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (found_slot),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_is_create  <= (i_s_axis_tuser == REQ_CREATE);
                        r_new_sp     <= i_s_axis_tdata - FRAME_BYTES;
                        r_res_slot   <= r_running;
                        r_res_sp     <= '0;
                        r_res_status <= 1'b0;
                        if (i_s_axis_tuser == REQ_SWITCH || i_s_axis_tuser == REQ_CREATE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (r_is_create) begin
                            if (scan_sts.at_end) begin
                                // table full
                                r_res_slot   <= '0;
                                r_res_status <= 1'b1;
                            end else begin
                                r_res_slot <= scan_idx[SLOT_W-1:0];
                                r_res_sp   <= r_new_sp;
                            end
                            r_state <= S_OUT;
                        end else begin
                            // past the last slot always lands on slot 0
                            r_running  <= found_slot;
                            r_res_slot <= found_slot;
                            r_state    <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_res_sp <= mem_rd_data;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (out_load) begin
            r_out_slot   <= res_slot_ext[2:0];
            r_out_sp     <= r_res_sp;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out_sp, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ----- sv/rrts_stack_mem.sv -----
// Saved stack pointer memory: one write port, one registered read port.
`timescale 1ns / 1ps

module rrts_stack_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/rrts_scan_unit.sv -----
// Task flag table with the shared slot counter and match compare.
`timescale 1ns / 1ps

module rrts_scan_unit #(
    parameter int TASK_SLOTS = rrts_pkg::DEF_TASK_SLOTS,
    parameter int SLOT_W     = $clog2(TASK_SLOTS),
    parameter int CNT_W      = $clog2(TASK_SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrts_pkg::t_scan_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_start_idx,
    input  logic [SLOT_W-1:0]   i_clr_idx,
    output rrts_pkg::t_scan_sts o_sts,
    output logic [CNT_W-1:0]    o_idx
);
    import rrts_pkg::*;

    logic [1:0]       r_flags [TASK_SLOTS];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [1:0]       rd_flags;
    logic             at_end;

    assign at_end   = (r_cnt >= CNT_W'(TASK_SLOTS));
    assign rd_flags = at_end ? 2'b00 : r_flags[r_cnt[SLOT_W-1:0]];

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.start) begin
            n_cnt = i_start_idx;
        end else if (i_ctl.step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_flags[i] <= 2'b00;
            end
        end else begin
            if (i_ctl.set_en && !at_end) begin
                r_flags[r_cnt[SLOT_W-1:0]] <= FLAG_IN_USE | FLAG_EXEC;
            end
            if (i_ctl.clr_en) begin
                r_flags[i_clr_idx] <= 2'b00;
            end
        end
        r_cnt <= n_cnt;
    end

    assign o_sts.at_end = at_end;
    assign o_sts.hit    = !at_end && (i_ctl.create_mode ? (rd_flags == 2'b00)
                                                       : ((rd_flags & FLAG_EXEC) != 2'b00));
    assign o_idx        = r_cnt;

endmodule
